FILE: src/bbd_pkg.sv
// Shared types and constants of the BGGR demosaic block.
package bbd_pkg;

   localparam int PIX_W         = 8;
   localparam int CFG_WIDTH_W   = 12;
   localparam int CFG_HEIGHT_W  = 13;
   localparam int CSR_DATA_W    = 13;
   localparam int CSR_INDEX_W   = 4;
   localparam int WIDTH_RESET   = 1024;
   localparam int HEIGHT_RESET  = 1024;
   localparam int NUM_LINES     = 4;

   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_WIDTH  = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_HEIGHT = 4'd1;

   localparam logic CMD_PIXEL = 1'b0;
   localparam logic CMD_DRAIN = 1'b1;

   typedef logic [1:0] line_type;

   // Line buffer roles relative to the line of the output row.
   localparam line_type ROLE_CURRENT = 2'd0;
   localparam line_type ROLE_BELOW   = 2'd1;
   localparam line_type ROLE_ABOVE   = 2'd3;

   typedef struct packed {
      line_type line;
      logic     row_odd;
      logic     col_odd;
      logic     right;
      logic     down;
      logic     up;
      logic     left;
      logic     bypass;
   } emit_info_type;

   typedef struct packed {
      logic [PIX_W-1:0] here;
      logic [PIX_W-1:0] right;
      logic [PIX_W-1:0] below;
      logic [PIX_W-1:0] below_right;
      logic [PIX_W-1:0] above_left;
      logic [PIX_W-1:0] left;
   } window_type;

   typedef struct packed {
      logic [PIX_W-1:0] blue;
      logic [PIX_W-1:0] green;
      logic [PIX_W-1:0] red;
      logic             end_of_row;
      logic             end_of_frame;
   } bgr_type;

endpackage

FILE: src/bayer_bggr_demosaic_core.sv
// Top level of the streaming BGGR Bayer demosaic core.
//
//   channel | direction | handshake             | payload
//   req     | in        | req_valid / req_stall | req_command, req_raw_pixel
//   rsp     | out       | rsp_valid / rsp_stall | rsp_blue, rsp_green, rsp_red,
//           |           |                       | rsp_end_of_row, rsp_end_of_frame
//   csr     | in        | csr_wr_en             | csr_index, csr_wdata
//
// One req transaction is taken per clock while req_stall is low. A result
// leaves through the registered read of the line RAMs followed by the result
// register, after the transaction that releases it.
// Synchronous reset clears the control state; the line RAMs are not cleared.
// A full result register under rsp_stall holds, and one more result waits in
// the read stage before req_stall rises.
module bayer_bggr_demosaic_core
   import bbd_pkg::*;
#(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_command,
   input  logic [PIX_W-1:0]       req_raw_pixel,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [PIX_W-1:0]       rsp_blue,
   output logic [PIX_W-1:0]       rsp_green,
   output logic [PIX_W-1:0]       rsp_red,
   output logic                   rsp_end_of_row,
   output logic                   rsp_end_of_frame,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int AW = $clog2(MAX_WIDTH);

   logic          accept;
   logic          emit;
   emit_info_type info;
   logic          wr_en;
   line_type      wr_line;
   logic [AW-1:0] wr_addr;
   logic [AW-1:0] rd_col;
   logic [AW-1:0] rd_col_prev;
   logic [AW-1:0] rd_col_next;

   logic out_free;
   logic s1_load;
   logic s1_move;

   logic          s1_valid_ff, s1_valid_in;
   emit_info_type s1_info_ff;
   logic [PIX_W-1:0] s1_pix_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   bgr_type       rsp_pix_ff;
   logic [PIX_W-1:0] last_here_ff;

   logic [NUM_LINES-1:0][PIX_W-1:0] rd0;
   logic [NUM_LINES-1:0][PIX_W-1:0] rd1;

   line_type   cur_l;
   line_type   below_l;
   line_type   above_l;
   window_type win;
   bgr_type    pix;

   // The read stage moves on whenever the result register is empty or being
   // taken; an input transaction is refused only while the read stage is
   // full and cannot move.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign s1_move   = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;
   assign accept    = req_valid && !req_stall;
   assign s1_load   = accept && emit;

   bbd_ctrl #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .accept      (accept),
      .command     (req_command),
      .emit        (emit),
      .info        (info),
      .wr_en       (wr_en),
      .wr_line     (wr_line),
      .wr_addr     (wr_addr),
      .rd_col      (rd_col),
      .rd_col_prev (rd_col_prev),
      .rd_col_next (rd_col_next)
   );

   // Four line RAMs selected by row modulo four. For an output in row i the
   // RAM of row i gives the sample and its right neighbor, the RAM of row i+1
   // gives the lower and lower-right samples, and the RAM of row i-1 gives the
   // upper-left sample on its first port. The RAM being written is never the
   // one holding row i-1.
   for (genvar k = 0; k < NUM_LINES; k++) begin : g_line
      line_type      role;
      logic [AW-1:0] addr0;

      assign role  = line_type'(k) - info.line;
      assign addr0 = (role == ROLE_ABOVE) ? rd_col_prev : rd_col;

      bbd_ram #(
         .WIDTH (PIX_W),
         .DEPTH (MAX_WIDTH)
      ) u_ram (
         .clock    (clock),
         .wr_en    (wr_en && (wr_line == line_type'(k))),
         .wr_addr  (wr_addr),
         .wr_data  (req_raw_pixel),
         .rd_en    (s1_load),
         .rd_addr0 (addr0),
         .rd_addr1 (rd_col_next),
         .rd_data0 (rd0[k]),
         .rd_data1 (rd1[k])
      );
   end

   // Assemble the neighborhood. When a sample transaction releases an output,
   // that sample is the lower-right neighbor and is written in the same cycle,
   // so it is taken from the read-stage register instead of the RAM. The left
   // neighbor is the previous output's own sample, kept in a register.
   assign cur_l   = s1_info_ff.line + ROLE_CURRENT;
   assign below_l = s1_info_ff.line + ROLE_BELOW;
   assign above_l = s1_info_ff.line + ROLE_ABOVE;

   assign win.here        = rd0[cur_l];
   assign win.right       = rd1[cur_l];
   assign win.below       = rd0[below_l];
   assign win.below_right = s1_info_ff.bypass ? s1_pix_ff : rd1[below_l];
   assign win.above_left  = rd0[above_l];
   assign win.left        = last_here_ff;

   bbd_color u_color (
      .info (s1_info_ff),
      .win  (win),
      .pix  (pix)
   );

   assign s1_valid_in  = s1_load || (s1_valid_ff && !out_free);
   assign rsp_valid_in = s1_move || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_info_ff <= info;
         s1_pix_ff  <= req_raw_pixel;
      end
      if (s1_move) begin
         rsp_pix_ff   <= pix;
         last_here_ff <= win.here;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_blue         = rsp_pix_ff.blue;
   assign rsp_green        = rsp_pix_ff.green;
   assign rsp_red          = rsp_pix_ff.red;
   assign rsp_end_of_row   = rsp_pix_ff.end_of_row;
   assign rsp_end_of_frame = rsp_pix_ff.end_of_frame;

endmodule

FILE: src/bbd_ram.sv
// Generic RAM with one write port and two registered read ports.
module bbd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr0,
   input  logic [$clog2(DEPTH)-1:0] rd_addr1,
   output logic [WIDTH-1:0]         rd_data0,
   output logic [WIDTH-1:0]         rd_data1
);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [WIDTH-1:0] rd_data0_ff;
   logic [WIDTH-1:0] rd_data1_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data0_ff <= store_ff[rd_addr0];
         rd_data1_ff <= store_ff[rd_addr1];
      end
   end

   assign rd_data0 = rd_data0_ff;
   assign rd_data1 = rd_data1_ff;

endmodule

FILE: src/bbd_ctrl.sv
// Frame geometry registers, input and output position counters and emit decision.
module bbd_ctrl
   import bbd_pkg::*;
#(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_wr_en,
   input  logic [CSR_INDEX_W-1:0]       csr_index,
   input  logic [CSR_DATA_W-1:0]        csr_wdata,
   input  logic                         accept,
   input  logic                         command,
   output logic                         emit,
   output emit_info_type                info,
   output logic                         wr_en,
   output line_type                     wr_line,
   output logic [$clog2(MAX_WIDTH)-1:0] wr_addr,
   output logic [$clog2(MAX_WIDTH)-1:0] rd_col,
   output logic [$clog2(MAX_WIDTH)-1:0] rd_col_prev,
   output logic [$clog2(MAX_WIDTH)-1:0] rd_col_next
);

   localparam int AW    = $clog2(MAX_WIDTH);
   localparam int WW    = $clog2(MAX_WIDTH + 1);
   localparam int HW    = $clog2(MAX_HEIGHT + 1);
   localparam int RW    = ($clog2(MAX_HEIGHT) < 2) ? 2 : $clog2(MAX_HEIGHT);
   localparam int GW    = $clog2(MAX_WIDTH + 3);
   localparam int W_RST = (WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RESET;
   localparam int H_RST = (HEIGHT_RESET > MAX_HEIGHT) ? MAX_HEIGHT : HEIGHT_RESET;

   logic [WW-1:0] w_ff, w_in;
   logic [HW-1:0] h_ff, h_in;
   logic [HW-1:0] in_row_ff, in_row_in;
   logic [AW-1:0] in_col_ff, in_col_in;
   logic [RW-1:0] out_row_ff, out_row_in;
   logic [AW-1:0] out_col_ff, out_col_in;
   logic [GW-1:0] gap_ff, gap_in;

   logic [CFG_WIDTH_W-1:0]  new_w_raw;
   logic [CFG_HEIGHT_W-1:0] new_h_raw;
   logic [WW-1:0]           new_w;
   logic [HW-1:0]           new_h;
   logic                    csr_hit;
   logic                    input_done;
   logic                    is_pixel;
   logic                    is_drain;
   logic                    px_take;
   logic                    px_emit;
   logic                    dr_emit;
   logic                    in_last_col;
   logic                    out_right;
   logic                    out_down;
   logic                    frame_last;

   // Out-of-range geometry is clamped at write time: zero acts as one.
   assign new_w_raw = csr_wdata[CFG_WIDTH_W-1:0];
   assign new_h_raw = csr_wdata[CFG_HEIGHT_W-1:0];
   assign new_w = (new_w_raw == '0) ? WW'(1) :
                  ((32'(new_w_raw) > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(new_w_raw));
   assign new_h = (new_h_raw == '0) ? HW'(1) :
                  ((32'(new_h_raw) > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(new_h_raw));
   assign csr_hit = csr_wr_en &&
                    (csr_index == CSR_FRAME_WIDTH || csr_index == CSR_FRAME_HEIGHT);

   assign is_pixel    = (command == CMD_PIXEL);
   assign is_drain    = (command == CMD_DRAIN);
   assign input_done  = (in_row_ff >= h_ff);
   assign in_last_col = (32'(in_col_ff) + 32'd1 == 32'(w_ff));
   assign out_right   = (32'(out_col_ff) + 32'd1 < 32'(w_ff));
   assign out_down    = (32'(out_row_ff) + 32'd1 < 32'(h_ff));

   // Once the input leads the output by a line plus two samples, every stored
   // sample emits one output position.
   assign px_take    = accept && is_pixel && !input_done;
   assign px_emit    = px_take && (32'(gap_ff) + 32'd1 >= 32'(w_ff) + 32'd2);
   assign dr_emit    = accept && is_drain && input_done;
   assign emit       = px_emit || dr_emit;
   assign frame_last = emit && !out_right && !out_down;

   always_comb begin
      w_in       = w_ff;
      h_in       = h_ff;
      in_row_in  = in_row_ff;
      in_col_in  = in_col_ff;
      out_row_in = out_row_ff;
      out_col_in = out_col_ff;
      gap_in     = gap_ff;
      if (csr_wr_en && csr_index == CSR_FRAME_WIDTH) begin
         w_in = new_w;
      end
      if (csr_wr_en && csr_index == CSR_FRAME_HEIGHT) begin
         h_in = new_h;
      end
      priority if (csr_hit || frame_last) begin
         in_row_in  = '0;
         in_col_in  = '0;
         out_row_in = '0;
         out_col_in = '0;
         gap_in     = '0;
      end else begin
         if (px_take) begin
            if (in_last_col) begin
               in_col_in = '0;
               in_row_in = in_row_ff + HW'(1);
            end else begin
               in_col_in = in_col_ff + AW'(1);
            end
            if (!px_emit) begin
               gap_in = gap_ff + GW'(1);
            end
         end
         if (emit) begin
            if (!out_right) begin
               out_col_in = '0;
               out_row_in = out_row_ff + RW'(1);
            end else begin
               out_col_in = out_col_ff + AW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         w_ff       <= WW'(W_RST);
         h_ff       <= HW'(H_RST);
         in_row_ff  <= '0;
         in_col_ff  <= '0;
         out_row_ff <= '0;
         out_col_ff <= '0;
         gap_ff     <= '0;
      end else begin
         w_ff       <= w_in;
         h_ff       <= h_in;
         in_row_ff  <= in_row_in;
         in_col_ff  <= in_col_in;
         out_row_ff <= out_row_in;
         out_col_ff <= out_col_in;
         gap_ff     <= gap_in;
      end
   end

   assign wr_en       = px_take;
   assign wr_line     = in_row_ff[1:0];
   assign wr_addr     = in_col_ff;
   assign rd_col      = out_col_ff;
   assign rd_col_prev = out_col_ff - AW'(1);
   assign rd_col_next = out_col_ff + AW'(1);

   assign info.line    = out_row_ff[1:0];
   assign info.row_odd = out_row_ff[0];
   assign info.col_odd = out_col_ff[0];
   assign info.right   = out_right;
   assign info.down    = out_down;
   assign info.up      = (out_row_ff != '0);
   assign info.left    = (out_col_ff != '0);
   assign info.bypass  = px_emit;

endmodule

FILE: src/bbd_color.sv
// Color reconstruction of one output position from its neighborhood samples.
module bbd_color
   import bbd_pkg::*;
(
   input  emit_info_type info,
   input  window_type    win,
   output bgr_type       pix
);

   localparam logic [1:0] SITE_BLUE    = 2'b00;
   localparam logic [1:0] SITE_GREEN_B = 2'b01;
   localparam logic [1:0] SITE_GREEN_R = 2'b10;
   localparam logic [1:0] SITE_RED     = 2'b11;

   logic [PIX_W:0] sum_right_below;
   logic [PIX_W:0] sum_left_below;

   assign sum_right_below = {1'b0, win.right} + {1'b0, win.below};
   assign sum_left_below  = {1'b0, win.left} + {1'b0, win.below};

   always_comb begin
      pix              = '0;
      pix.end_of_row   = !info.right;
      pix.end_of_frame = !info.right && !info.down;
      unique case ({info.row_odd, info.col_odd})
         SITE_BLUE: begin
            pix.blue = win.here;
            if (info.right && info.down) begin
               pix.green = sum_right_below[PIX_W:1];
               pix.red   = win.below_right;
            end
         end
         SITE_GREEN_B: begin
            pix.blue  = info.right ? win.right : '0;
            pix.green = win.here;
            pix.red   = info.down ? win.below : '0;
         end
         SITE_GREEN_R: begin
            pix.blue  = info.down ? win.below : '0;
            pix.green = win.here;
            pix.red   = info.right ? win.right : '0;
         end
         SITE_RED: begin
            pix.blue  = (info.up && info.left) ? win.above_left : '0;
            pix.green = (info.left && info.down) ? sum_left_below[PIX_W:1] : '0;
            pix.red   = win.here;
         end
      endcase
   end

endmodule

FILE: src/bbd_checker.sv
// Port-level assertions for the demosaic core and the bind that attaches them.
module bbd_checker
   import bbd_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input logic [PIX_W-1:0] rsp_blue,
   input logic [PIX_W-1:0] rsp_green,
   input logic [PIX_W-1:0] rsp_red,
   input logic             rsp_end_of_row,
   input logic             rsp_end_of_frame
);

   // Reset leaves no result pending.
   a_reset_empties: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // Input is refused only when the result side is full and blocked.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled while the result side can move");

   // A result that appears on an empty output comes from a transaction taken
   // earlier that passed the read stage and then the result register.
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall, 2))
      else $error("result appeared without a matching input transaction");

   a_result_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid &&
         $stable({rsp_blue, rsp_green, rsp_red, rsp_end_of_row, rsp_end_of_frame})))
      else $error("stalled result changed");

endmodule

bind bayer_bggr_demosaic_core bbd_checker u_checker (.*);

FILE: verif/bayer_bggr_demosaic_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of the streaming BGGR demosaic core, with its own pixel predictor.
module bayer_bggr_demosaic_core_tb;
   import bbd_pkg::*;

   // The line store of the block holds one full row of this many samples.
   localparam int LINE_MAX       = 2048;
   localparam int ROWS_MAX       = 4096;
   localparam int MAX_IDLE       = 16;
   // A result leaves through the read stage and the result register, so this settling
   // time is enough for anything still in the pipeline to show up.
   localparam int SETTLE_CYCLES  = 8;
   localparam int HOLD_CYCLES    = 400;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int RANDOM_ITEMS   = 650;
   localparam int REPORT_LIMIT   = 10;

   logic                   clock            = 1'b0;
   logic                   reset            = 1'b1;
   logic                   req_valid        = 1'b0;
   logic                   req_stall;
   logic                   req_command      = CMD_PIXEL;
   logic [PIX_W-1:0]       req_raw_pixel    = '0;
   logic                   rsp_valid;
   logic                   rsp_stall        = 1'b0;
   logic [PIX_W-1:0]       rsp_blue;
   logic [PIX_W-1:0]       rsp_green;
   logic [PIX_W-1:0]       rsp_red;
   logic                   rsp_end_of_row;
   logic                   rsp_end_of_frame;
   logic                   csr_wr_en        = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index        = CSR_FRAME_WIDTH;
   logic [CSR_DATA_W-1:0]  csr_wdata        = '0;

   // Idling switches for each side, and the request for one long receiver stall.
   bit req_idle_on       = 1'b1;
   bit rsp_idle_on       = 1'b1;
   bit long_hold_pending = 1'b0;

   int unsigned mismatches = 0;

   bayer_bggr_demosaic_core #(
      .MAX_WIDTH (LINE_MAX),
      .MAX_HEIGHT(ROWS_MAX)
   ) uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_command     (req_command),
      .req_raw_pixel   (req_raw_pixel),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_blue        (rsp_blue),
      .rsp_green       (rsp_green),
      .rsp_red         (rsp_red),
      .rsp_end_of_row  (rsp_end_of_row),
      .rsp_end_of_frame(rsp_end_of_frame),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always #6 clock = ~clock;

   // ------------------------------------------------------------------
   // Demosaic predictor.
   // The mosaic is kept as four rows selected by row mod 4. Only samples of
   // the current frame that have already arrived are ever read, so the
   // contents left over from an earlier frame never matter.
   // ------------------------------------------------------------------
   logic [PIX_W-1:0]        mosaic_lines [NUM_LINES][LINE_MAX];
   logic [CFG_WIDTH_W-1:0]  width_reg  = CFG_WIDTH_W'(WIDTH_RESET);
   logic [CFG_HEIGHT_W-1:0] height_reg = CFG_HEIGHT_W'(HEIGHT_RESET);
   int unsigned             in_row     = 0;
   int unsigned             in_col     = 0;
   int unsigned             out_row    = 0;
   int unsigned             out_col    = 0;

   // BGR pixels that the block owes, oldest first.
   bgr_type bgr_due [$];

   // A width of zero acts as one, and anything beyond the line store is clamped.
   function automatic int unsigned active_width();
      if (width_reg == '0) return 1;
      return (width_reg > LINE_MAX) ? LINE_MAX : width_reg;
   endfunction

   function automatic int unsigned active_height();
      if (height_reg == '0) return 1;
      return (height_reg > ROWS_MAX) ? ROWS_MAX : height_reg;
   endfunction

   function automatic logic [PIX_W-1:0] mosaic_at(int unsigned row, int unsigned col);
      return mosaic_lines[row % NUM_LINES][col];
   endfunction

   function automatic void restart_frame();
      in_row  = 0;
      in_col  = 0;
      out_row = 0;
      out_col = 0;
   endfunction

   // Builds the BGR pixel at the output position and moves that position on.
   function automatic bgr_type next_bgr_pixel(int unsigned w, int unsigned h);
      bgr_type        px;
      logic [PIX_W:0] sum;
      int unsigned    i;
      int unsigned    j;
      bit             down;
      bit             right;
      bit             up;
      bit             left;
      i     = out_row;
      j     = out_col;
      down  = (i + 1) < h;
      right = (j + 1) < w;
      up    = i > 0;
      left  = j > 0;
      px    = '0;
      case ({i[0], j[0]})
         2'b00: begin
            // Blue site: green averages right and lower, red sits diagonally below.
            px.blue = mosaic_at(i, j);
            if (right && down) begin
               sum      = mosaic_at(i, j + 1) + mosaic_at(i + 1, j);
               px.green = sum[PIX_W:1];
               px.red   = mosaic_at(i + 1, j + 1);
            end
         end
         2'b01: begin
            // Green site on a blue row: blue to the right, red below.
            if (right) px.blue = mosaic_at(i, j + 1);
            px.green = mosaic_at(i, j);
            if (down) px.red = mosaic_at(i + 1, j);
         end
         2'b10: begin
            // Green site on a red row: blue below, red to the right.
            if (down) px.blue = mosaic_at(i + 1, j);
            px.green = mosaic_at(i, j);
            if (right) px.red = mosaic_at(i, j + 1);
         end
         default: begin
            // Red site: blue from the upper left, green averages left and lower.
            if (up && left) px.blue = mosaic_at(i - 1, j - 1);
            if (left && down) begin
               sum      = mosaic_at(i, j - 1) + mosaic_at(i + 1, j);
               px.green = sum[PIX_W:1];
            end
            px.red = mosaic_at(i, j);
         end
      endcase
      px.end_of_row   = !right;
      px.end_of_frame = !right && !down;
      if (!right && !down) begin
         restart_frame();
      end else if (!right) begin
         out_col = 0;
         out_row++;
      end else begin
         out_col++;
      end
      return px;
   endfunction

   // Follows one accepted input transaction and records the pixel it releases.
   function automatic void track_bayer_input(logic cmd, logic [PIX_W-1:0] pix);
      int unsigned w;
      int unsigned h;
      int unsigned sent;
      int unsigned recv;
      w    = active_width();
      h    = active_height();
      sent = out_row * w + out_col;
      if (cmd == CMD_PIXEL) begin
         // A sample after the whole frame has arrived is dropped.
         if (in_row >= h) return;
         mosaic_lines[in_row % NUM_LINES][in_col] = pix;
         in_col++;
         if (in_col >= w) begin
            in_col = 0;
            in_row++;
         end
         // An output needs its lower right neighbour, one line plus one pixel ahead.
         recv = in_row * w + in_col;
         if (recv >= sent + w + 2) bgr_due.push_back(next_bgr_pixel(w, h));
      end else if (in_row >= h && sent < w * h) begin
         // Drain ticks only release pixels once the frame is fully in.
         bgr_due.push_back(next_bgr_pixel(w, h));
      end
   endfunction

   // A write to the width or height register abandons the frame in progress.
   function automatic void track_csr_write(logic [CSR_INDEX_W-1:0] idx,
                                           logic [CSR_DATA_W-1:0] data);
      if (idx == CSR_FRAME_WIDTH) begin
         width_reg = data[CFG_WIDTH_W-1:0];
         restart_frame();
      end else if (idx == CSR_FRAME_HEIGHT) begin
         height_reg = data[CFG_HEIGHT_W-1:0];
         restart_frame();
      end
   endfunction

   // ------------------------------------------------------------------
   // Stimulus helpers.
   // ------------------------------------------------------------------
   function automatic logic [PIX_W-1:0] random_sample();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         default: return PIX_W'($urandom_range(0, 255));
      endcase
   endfunction

   // Offers one transaction after a random gap and waits until it is taken.
   // Valid stays high between back-to-back transactions; only the payload moves.
   task automatic send_item(logic cmd, logic [PIX_W-1:0] pix);
      int unsigned gap;
      gap = req_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_command   <= cmd;
      req_raw_pixel <= pix;
      do @(posedge clock); while (req_stall);
      track_bayer_input(cmd, pix);
   endtask

   // Stops offering, waits for every owed pixel and lets the pipeline settle,
   // so that dropped samples or drain ticks still in flight are done too.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (bgr_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      track_csr_write(idx, data);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure_frame(logic [CSR_DATA_W-1:0] w, logic [CSR_DATA_W-1:0] h);
      wait_idle();
      write_csr(CSR_FRAME_WIDTH, w);
      write_csr(CSR_FRAME_HEIGHT, h);
   endtask

   // Sends drain ticks until the frame is closed, optionally mixing in samples
   // that arrive after the frame is complete and must be dropped.
   task automatic drain_frame(bit with_noise);
      while (in_row >= active_height()) begin
         if (with_noise && $urandom_range(0, 5) == 0) send_item(CMD_PIXEL, random_sample());
         send_item(CMD_DRAIN, random_sample());
      end
   endtask

   // ------------------------------------------------------------------
   // Tests.
   // ------------------------------------------------------------------

   // Out of reset the frame is 1024 x 1024; the first pixel comes out once a
   // line plus two samples are in. The frame is then left unfinished and the
   // next register write abandons it.
   task automatic test_reset_defaults();
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      repeat (WIDTH_RESET + 6) send_item(CMD_PIXEL, random_sample());
      wait_idle();
   endtask

   task automatic test_directed_cases();
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
      // Zero width and height act as a single pixel frame. A drain with nothing
      // pending gives nothing, and a sample after the frame is full is dropped.
      configure_frame('0, '0);
      send_item(CMD_DRAIN, 8'h00);
      send_item(CMD_PIXEL, 8'hFF);
      send_item(CMD_PIXEL, 8'h00);
      send_item(CMD_DRAIN, 8'hFF);
      send_item(CMD_DRAIN, 8'h00);
      // A 2 x 2 frame with full scale green samples checks the green average at its top.
      // The drain before the frame is complete must not release anything.
      configure_frame(2, 2);
      send_item(CMD_PIXEL, 8'hFF);
      send_item(CMD_PIXEL, 8'hFF);
      send_item(CMD_DRAIN, 8'h00);
      send_item(CMD_PIXEL, 8'hFF);
      send_item(CMD_PIXEL, 8'h00);
      drain_frame(1'b0);
      send_item(CMD_DRAIN, 8'h00);
      // Bit 12 of the write data lies above the width register and is dropped,
      // which leaves an odd width of three.
      configure_frame(13'h1003, 2);
      send_item(CMD_PIXEL, 8'hFF);
      send_item(CMD_PIXEL, 8'h00);
      send_item(CMD_PIXEL, 8'hAA);
      send_item(CMD_PIXEL, 8'h55);
      send_item(CMD_PIXEL, 8'hFF);
      send_item(CMD_PIXEL, 8'hFF);
      drain_frame(1'b0);
   endtask

   // The receiver stalls for a long stretch right after the first pixel of the
   // frame while the sender keeps going, so the block has to stall its input.
   task automatic test_backpressure();
      configure_frame(8, 6);
      req_idle_on       = 1'b0;
      rsp_idle_on       = 1'b0;
      long_hold_pending = 1'b1;
      repeat (48) send_item(CMD_PIXEL, random_sample());
      drain_frame(1'b0);
      wait_idle();
   endtask

   // Mostly whole frames of random small sizes with random content; now and
   // then a stray drain inside a frame, dropped samples during the drain, a
   // frame run again without new settings, or a frame abandoned partway.
   task automatic test_random_frames();
      int unsigned sent_items;
      int unsigned w;
      int unsigned h;
      int unsigned n;
      bit          must_configure;
      bit          abandon;
      sent_items     = 0;
      must_configure = 1'b1;
      while (sent_items < RANDOM_ITEMS) begin
         req_idle_on = ($urandom_range(0, 3) != 0);
         rsp_idle_on = ($urandom_range(0, 3) != 0);
         if (must_configure || $urandom_range(0, 9) < 7) begin
            case ($urandom_range(0, 9))
               0:       w = 1;
               1:       w = 2;
               8:       w = $urandom_range(13, 40);
               default: w = $urandom_range(3, 12);
            endcase
            h = ($urandom_range(0, 5) == 0) ? 1 : $urandom_range(2, 8);
            wait_idle();
            // Sometimes only one register changes and the other one is kept.
            case ($urandom_range(0, 6))
               0:       write_csr(CSR_FRAME_WIDTH, CSR_DATA_W'(w));
               1:       write_csr(CSR_FRAME_HEIGHT, CSR_DATA_W'(h));
               default: begin
                  write_csr(CSR_FRAME_WIDTH, CSR_DATA_W'(w));
                  write_csr(CSR_FRAME_HEIGHT, CSR_DATA_W'(h));
               end
            endcase
         end
         w       = active_width();
         h       = active_height();
         abandon = ($urandom_range(0, 9) == 0);
         n       = abandon ? $urandom_range(0, w * h - 1) : w * h;
         repeat (n) begin
            if ($urandom_range(0, 23) == 0) send_item(CMD_DRAIN, random_sample());
            send_item(CMD_PIXEL, random_sample());
         end
         sent_items += n;
         must_configure = abandon;
         if (!abandon) begin
            drain_frame(1'b1);
            sent_items += w + 1;
            if ($urandom_range(0, 7) == 0) send_item(CMD_DRAIN, random_sample());
         end
      end
   endtask

   // ------------------------------------------------------------------
   // Result checker: takes each result transaction after a random stall, if idling is on, and
   // compares it field by field with the oldest owed pixel.
   // ------------------------------------------------------------------
   function automatic void note_failure(string msg);
      mismatches++;
      if (mismatches <= REPORT_LIMIT) $display("%s", msg);
   endfunction

   initial begin : bgr_checker
      int unsigned hold;
      bgr_type     got;
      bgr_type     want;
      @(posedge clock);
      forever begin
         hold = rsp_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
         if (long_hold_pending) begin
            hold              = HOLD_CYCLES;
            long_hold_pending = 1'b0;
         end
         if (hold != 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
         got = {rsp_blue, rsp_green, rsp_red, rsp_end_of_row, rsp_end_of_frame};
         if (bgr_due.size() == 0) begin
            note_failure($sformatf("unexpected pixel b=%0d g=%0d r=%0d eor=%0b eof=%0b",
                                   got.blue, got.green, got.red,
                                   got.end_of_row, got.end_of_frame));
         end else begin
            want = bgr_due.pop_front();
            if (got != want) begin
               note_failure($sformatf({"pixel mismatch: expected b=%0d g=%0d r=%0d ",
                                       "eor=%0b eof=%0b, got b=%0d g=%0d r=%0d ",
                                       "eor=%0b eof=%0b"},
                                      want.blue, want.green, want.red,
                                      want.end_of_row, want.end_of_frame,
                                      got.blue, got.green, got.red,
                                      got.end_of_row, got.end_of_frame));
            end
         end
      end
   end

   // Ends the run when no transaction moves on either channel for too long.
   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
         else quiet++;
      end
      $display("[bayer_bggr_demosaic_core] ERROR");
      $finish;
   end

   initial begin : test_sequence
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_directed_cases();
      test_backpressure();
      test_random_frames();
      wait_idle();
      if (mismatches == 0) begin
         $display("[bayer_bggr_demosaic_core] OK");
      end else begin
         $display("[bayer_bggr_demosaic_core] ERROR");
      end
      $finish;
   end

endmodule

FILE: files.f
src/bbd_pkg.sv
src/bbd_ram.sv
src/bbd_ctrl.sv
src/bbd_color.sv
src/bayer_bggr_demosaic_core.sv
src/bbd_checker.sv
verif/bayer_bggr_demosaic_core_tb.sv
